[rtl/sam_pkg.sv]
package sam_pkg;

	// Number of cells in the sorting chain, which is also the most samples in one set.
	localparam int DEPTH = 32;
	// Width of one signed Q16.16 sample.
	localparam int SAMPLE_W = 32;
	// Sample count, able to hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Index of one cell.
	localparam int IDX_W = $clog2(DEPTH);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Per-cycle command that is broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic rotate;
		logic shift;
	} chain_ctrl_t;

endpackage

[rtl/sam_if.sv]
// Input channel: one sample word per handshake.
interface sam_in_if;
	import sam_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// Output channel: one sorted word per handshake.
interface sam_out_if;
	import sam_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sorted_sample;
	sample_t median_value;
	logic    last_result;
	logic    overflow;

	modport source (output valid, output sorted_sample, output median_value,
		output last_result, output overflow, input ready);
	modport sink (input valid, input sorted_sample, input median_value,
		input last_result, input overflow, output ready);
endinterface

[rtl/sam_cell.sv]
module sam_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sam_pkg::chain_ctrl_t ctrl,
	input  sam_pkg::sample_t     new_val,
	input  sam_pkg::sample_t     prev_val,
	input  logic                 prev_valid,
	input  logic                 prev_take,
	input  sam_pkg::sample_t     next_val,
	input  logic                 next_valid,
	output sam_pkg::sample_t     val,
	output logic                 valid,
	output logic                 take
);
	import sam_pkg::*;

	sample_t val_q;
	logic    valid_q;

	// The new word belongs at or before this cell when the cell is empty or holds a larger value.
	assign take  = !valid_q || (new_val < val_q);
	assign val   = val_q;
	assign valid = valid_q;

	// Valid flag: follows the neighbor on a move, and is set when the cell gains a value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.rotate || ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && take && (prev_valid || !prev_take)) begin
			valid_q <= 1'b1;
		end
	end

	// Value: on insert the first cell that takes stores the new word and the cells behind
	// it move up by one; on rotate or shift the value moves toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.rotate || ctrl.shift) begin
			val_q <= next_val;
		end else if (ctrl.insert && take) begin
			if (prev_take && prev_valid) begin
				val_q <= prev_val;
			end else if (!prev_take) begin
				val_q <= new_val;
			end
		end
	end

endmodule

[rtl/sam_chain.sv]
module sam_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sam_pkg::chain_ctrl_t ctrl,
	input  sam_pkg::sample_t     new_val,
	output sam_pkg::sample_t     head_val
);
	import sam_pkg::*;

	sample_t vals   [DEPTH];
	logic    valids [DEPTH];
	logic    takes  [DEPTH];

	// Row of cells; cell 0 is the head and holds the smallest value.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sample_t prev_val;
		logic    prev_valid;
		logic    prev_take;
		sample_t next_val;
		logic    next_valid;

		if (i == 0) begin : g_head
			assign prev_val   = '0;
			assign prev_valid = 1'b0;
			assign prev_take  = 1'b0;
		end else begin : g_body
			assign prev_val   = vals[i-1];
			assign prev_valid = valids[i-1];
			assign prev_take  = takes[i-1];
		end

		// The tail closes the ring on rotate and pulls in an empty slot on shift.
		if (i == DEPTH - 1) begin : g_tail
			assign next_val   = vals[0];
			assign next_valid = ctrl.rotate & valids[0];
		end else begin : g_mid
			assign next_val   = vals[i+1];
			assign next_valid = valids[i+1];
		end

		sam_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_val    (new_val),
			.prev_val   (prev_val),
			.prev_valid (prev_valid),
			.prev_take  (prev_take),
			.next_val   (next_val),
			.next_valid (next_valid),
			.val        (vals[i]),
			.valid      (valids[i]),
			.take       (takes[i])
		);
	end

	assign head_val = vals[0];

endmodule

[rtl/sort_and_median_top.sv]
// Each accepted sample is inserted into the sorted cell chain unless it is full, so loading runs
// at one word per cycle; the set is always sorted once the marked word is in.
// After the marked word, the chain rotates through all DEPTH cells to pick up the two middle
// values, ST_MED forms the median, and ST_OUT registers the first result.
// Results then leave one per cycle from the head cell while the receiver is ready.
// Reset clears the state, the sample count, the overflow flag and every cell's valid flag.
module sort_and_median_top (
	input  logic      clk,
	input  logic      arst_n,
	sam_in_if.sink    sample_ch,
	sam_out_if.source result_ch
);
	import sam_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROT,
		ST_MED,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     rot_q;
	logic                 ovf_q;
	logic                 out_valid_q;
	sample_t              a_q;
	sample_t              b_q;
	sample_t              med_q;
	sample_t              out_sample_q;
	sample_t              out_median_q;
	logic                 out_last_q;
	logic                 out_ovf_q;

	chain_ctrl_t          ctrl;
	sample_t              head_val;
	logic                 in_fire;
	logic                 full;
	logic                 out_free;
	logic                 out_load;
	logic [CNT_W-1:0]     half;
	logic [CNT_W-1:0]     rot_ext;
	logic                 grab_a;
	logic                 grab_b;
	logic signed [SAMPLE_W:0] pair_sum;

	// Handshake and chain commands.
	assign sample_ch.ready = (state_q == ST_LOAD);
	assign in_fire         = sample_ch.valid && sample_ch.ready;
	assign full            = (count_q == CNT_W'(DEPTH));
	assign out_free        = !out_valid_q || result_ch.ready;
	assign out_load        = (state_q == ST_OUT) && (count_q != '0) && out_free;

	assign ctrl.insert = in_fire && !full;
	assign ctrl.rotate = (state_q == ST_ROT);
	assign ctrl.shift  = out_load;

	// During the rotation the head shows each cell in turn; catch the middle ones.
	assign half    = count_q >> 1;
	assign rot_ext = CNT_W'(rot_q);
	assign grab_b  = ctrl.rotate && (rot_ext == half);
	assign grab_a  = ctrl.rotate && ((rot_ext + CNT_W'(1)) == half);

	// Exact sum of the two middle values; dropping the low bit floors the half.
	assign pair_sum = {a_q[SAMPLE_W-1], a_q} + {b_q[SAMPLE_W-1], b_q};

	sam_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.new_val  (sample_ch.sample),
		.head_val (head_val)
	);

	// Sequencer: load, rotate, median, drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			rot_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (sample_ch.last_sample) begin
							rot_q   <= '0;
							state_q <= ST_ROT;
						end
					end
				end
				ST_ROT: begin
					rot_q <= rot_q + IDX_W'(1);
					if (rot_q == IDX_W'(DEPTH - 1)) begin
						state_q <= ST_MED;
					end
				end
				ST_MED: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						count_q <= count_q - CNT_W'(1);
					end
					if (count_q == '0) begin
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Middle values, median and the output word.
	always_ff @(posedge clk) begin
		if (grab_a) begin
			a_q <= head_val;
		end
		if (grab_b) begin
			b_q <= head_val;
		end
		if (state_q == ST_MED) begin
			med_q <= count_q[0] ? b_q : pair_sum[SAMPLE_W:1];
		end
		if (out_load) begin
			out_sample_q <= head_val;
			out_median_q <= med_q;
			out_last_q   <= (count_q == CNT_W'(1));
			out_ovf_q    <= ovf_q;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.sorted_sample = out_sample_q;
	assign result_ch.median_value  = out_median_q;
	assign result_ch.last_result   = out_last_q;
	assign result_ch.overflow      = out_ovf_q;

endmodule

[rtl/sam_checker.sv]
module sam_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_last,
	input logic             out_valid,
	input logic             out_ready,
	input logic             out_last,
	input sam_pkg::sample_t out_median
);
	import sam_pkg::*;

	// A result word waits until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	// The marked sample closes the set, so no sample is taken in the next cycle.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("sample accepted right after the marked sample");

	// After the largest word of a run no other word can follow at once.
	a_run_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("result word right after the end of a run");

	// The median is the same on every word of one run.
	a_median_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !out_valid || (out_median == $past(out_median)))
		else $error("median changed within a run");

endmodule

bind sort_and_median_top sam_checker u_sam_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.in_last    (sample_ch.last_sample),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.out_last   (result_ch.last_result),
	.out_median (result_ch.median_value)
);
